FILE: rtl/csv_stream_tokenizer_top_defines.svh
// Assertion macros for the CSV stream tokenizer.
`ifndef CSV_STREAM_TOKENIZER_TOP_DEFINES_SVH
`define CSV_STREAM_TOKENIZER_TOP_DEFINES_SVH

`ifndef SYNTH
// a holds at this edge, so b holds at the same edge
`define CSVT_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("csv tokenizer: same-cycle check failed");
// a holds at this edge, so b holds at the next edge
`define CSVT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("csv tokenizer: next-cycle check failed");
`else
`define CSVT_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define CSVT_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

FILE: rtl/csvt_pkg.sv
// Shared types, codes and constants of the CSV stream tokenizer.
package csvt_pkg;

	localparam int COUNT_BITS_DEF = 24;
	localparam int BYTE_W         = 8;
	localparam int FIELD_W        = 24;
	localparam int KIND_W         = 3;

	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

	localparam logic ACTION_BYTE = 1'b0;
	localparam logic ACTION_END  = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE      = 3'd0,
		KIND_DATA      = 3'd1,
		KIND_FIELD     = 3'd2,
		KIND_ROW       = 3'd3,
		KIND_END_OK    = 3'd4,
		KIND_QUOTE_ERR = 3'd5,
		KIND_COUNT_ERR = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_QUOTED  = 2'd1,
		MODE_PENDING = 2'd2
	} mode_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DIV  = 1'b1
	} state_t;

	// status of the remainder unit
	typedef struct packed {
		logic done;
		logic rem_zero;
	} rem_stat_t;

endpackage

FILE: rtl/csvt_rem.sv
// Iterative restoring remainder unit: one dividend bit per cycle.
module csvt_rem import csvt_pkg::*; #(
	parameter int W = COUNT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output rem_stat_t    stat
);

	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     dvd_q;
	logic [W-1:0]     dvs_q;

	logic [W:0]       shifted;
	logic [W+1:0]     diff;
	logic [W-1:0]     rem_next;

	always_comb begin
		shifted  = {rem_q, dvd_q[W-1]};
		diff     = {1'b0, shifted} - {2'b00, dvs_q};
		// no borrow: shifted >= divisor, keep the difference
		rem_next = diff[W+1] ? shifted[W-1:0] : diff[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && cnt_q == CNT_W'(1)) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
			cnt_q <= CNT_W'(W);
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign stat.done     = done_q;
	assign stat.rem_zero = (rem_q == '0);

endmodule

FILE: rtl/csv_stream_tokenizer_top.sv
// Top level of the CSV stream tokenizer: byte classifier, counters and end check.
//
// channel  dir  tdata                      tuser
// s_*      in   [7:0] byte_value           [0] action (0 byte, 1 end)
// m_*      out  [7:0] out_byte,            [2:0] kind
//               [31:8] field_total, [55:32] row_total
//
// A byte item is classified in the cycle it is accepted; its result sits in the
// output register, so a new byte is taken whenever that register is empty or drained.
// An end item with a clean quote state and a nonzero row count runs the remainder unit,
// one bit per cycle, loading once done with a free slot; other end items load when accepted.
// s_tready is low while the remainder runs or while the output register holds a stalled item.
// Reset is asynchronous, active low; it clears mode, counters and the output valid.
`include "csv_stream_tokenizer_top_defines.svh"

module csv_stream_tokenizer_top import csvt_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic [0:0]  s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [7:0] out_byte, [31:8] field_total, [55:32] row_total
	output logic [2:0]  m_tuser    // [2:0] kind
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	state_t                state_q, state_d;
	mode_t                 mode_q, mode_d;
	logic [COUNT_BITS-1:0] field_q, field_d;
	logic [COUNT_BITS-1:0] row_q, row_d;

	logic                  m_valid_q;
	kind_t                 kind_q;
	logic [BYTE_W-1:0]     byte_q;
	logic [FIELD_W-1:0]    ftot_q, rtot_q;

	logic                  slot_free;
	logic                  in_acc;
	logic                  action;
	logic [BYTE_W-1:0]     in_byte;
	logic                  load;
	logic                  rem_start;
	kind_t                 kind_d;
	logic [BYTE_W-1:0]     byte_d;
	logic [COUNT_BITS-1:0] rep_field, rep_row;
	logic [FIELD_W+COUNT_BITS-1:0] field_ext, row_ext;

	// outside-quotes classification of the incoming byte
	kind_t                 nk;
	logic [BYTE_W-1:0]     nb;
	mode_t                 nmode;
	logic                  nf_inc, nr_inc;
	logic [COUNT_BITS-1:0] field_inc, row_inc;

	rem_stat_t             rem_stat;

	csvt_rem #(.W(COUNT_BITS)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (field_q),
		.divisor  (row_q),
		.stat     (rem_stat)
	);

	assign action  = s_tuser[0];
	assign in_byte = s_tdata;

	assign slot_free = !m_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && slot_free;
	assign in_acc    = s_tvalid && s_tready;

	assign field_inc = (field_q == CNT_MAX) ? field_q : field_q + COUNT_BITS'(1);
	assign row_inc   = (row_q == CNT_MAX) ? row_q : row_q + COUNT_BITS'(1);

	always_comb begin
		nk     = KIND_DATA;
		nb     = in_byte;
		nmode  = MODE_NORMAL;
		nf_inc = 1'b0;
		nr_inc = 1'b0;
		case (in_byte)
			CH_QUOTE: begin
				nk    = KIND_NONE;
				nb    = '0;
				nmode = MODE_QUOTED;
			end
			CH_COMMA: begin
				nk     = KIND_FIELD;
				nb     = '0;
				nf_inc = 1'b1;
			end
			CH_CR: begin
				nk = KIND_NONE;
				nb = '0;
			end
			CH_LF: begin
				nk     = KIND_ROW;
				nb     = '0;
				nf_inc = 1'b1;
				nr_inc = 1'b1;
			end
			default: begin
				nk = KIND_DATA;
				nb = in_byte;
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		field_d   = field_q;
		row_d     = row_q;
		load      = 1'b0;
		rem_start = 1'b0;
		kind_d    = KIND_NONE;
		byte_d    = '0;
		rep_field = field_q;
		rep_row   = row_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (action == ACTION_END) begin
						if (mode_q == MODE_QUOTED || mode_q == MODE_PENDING) begin
							load    = 1'b1;
							kind_d  = KIND_QUOTE_ERR;
							mode_d  = MODE_NORMAL;
							field_d = '0;
							row_d   = '0;
						end else if (row_q == '0) begin
							load    = 1'b1;
							kind_d  = KIND_COUNT_ERR;
							mode_d  = MODE_NORMAL;
							field_d = '0;
							row_d   = '0;
						end else begin
							rem_start = 1'b1;
							state_d   = ST_DIV;
						end
					end else begin
						load = 1'b1;
						case (mode_q)
							MODE_QUOTED: begin
								if (in_byte == CH_QUOTE) begin
									mode_d = MODE_PENDING;
									kind_d = KIND_NONE;
								end else begin
									kind_d = KIND_DATA;
									byte_d = in_byte;
								end
							end
							MODE_PENDING: begin
								if (in_byte == CH_QUOTE) begin
									// doubled quote: one literal quote
									mode_d = MODE_QUOTED;
									kind_d = KIND_DATA;
									byte_d = CH_QUOTE;
								end else begin
									mode_d  = nmode;
									kind_d  = nk;
									byte_d  = nb;
									field_d = nf_inc ? field_inc : field_q;
									row_d   = nr_inc ? row_inc : row_q;
								end
							end
							default: begin
								mode_d  = nmode;
								kind_d  = nk;
								byte_d  = nb;
								field_d = nf_inc ? field_inc : field_q;
								row_d   = nr_inc ? row_inc : row_q;
							end
						endcase
						rep_field = field_d;
						rep_row   = row_d;
					end
				end
			end
			ST_DIV: begin
				if (rem_stat.done && slot_free) begin
					load    = 1'b1;
					kind_d  = rem_stat.rem_zero ? KIND_END_OK : KIND_COUNT_ERR;
					mode_d  = MODE_NORMAL;
					field_d = '0;
					row_d   = '0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign field_ext = {{FIELD_W{1'b0}}, rep_field};
	assign row_ext   = {{FIELD_W{1'b0}}, rep_row};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= MODE_NORMAL;
			field_q   <= '0;
			row_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			field_q <= field_d;
			row_q   <= row_d;
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_d;
			byte_q <= byte_d;
			ftot_q <= field_ext[FIELD_W-1:0];
			rtot_q <= row_ext[FIELD_W-1:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {rtot_q, ftot_q, byte_q};
	assign m_tuser  = kind_q;

	`CSVT_ASSERT_NEXT(a_end_starts_div, clk, arst_n,
		in_acc && action == ACTION_END && mode_q == MODE_NORMAL && row_q != '0,
		state_q == ST_DIV)
	`CSVT_ASSERT_NEXT(a_div_holds_counts, clk, arst_n,
		state_q == ST_DIV && !rem_stat.done,
		$stable(field_q) && $stable(row_q))
	`CSVT_ASSERT_NEXT(a_end_clears_state, clk, arst_n,
		load && (kind_d == KIND_END_OK || kind_d == KIND_QUOTE_ERR ||
			kind_d == KIND_COUNT_ERR),
		field_q == '0 && row_q == '0 && mode_q == MODE_NORMAL)

endmodule
